// File: rtl/assert_macros.svh
// Assertion shorthands for the histogram block checker.
// Plain text macros; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define RHBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define RHBS_NEVER(lbl, clk, rstn, cond, msg) \
  `RHBS_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// File: rtl/rhbs_pkg.sv
// Shared constants for the RGB histogram bar scaler.
// No dependencies.
`default_nettype none

package rhbs_pkg;

  localparam int NUM_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int BAR_TOP_DEF     = 511;

  // Pixel and bin index field width on the input side
  localparam int PIX_W      = 8;
  localparam int IN_TDATA_W = 4 * PIX_W;

  // Command codes carried in tuser
  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: rtl/rhbs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module rhbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/rhbs_bar_div.sv
// Bar length divider: one quotient bit per cycle, result clamped to BAR_TOP.
// No dependencies; instanced by the top level once per channel.
`default_nettype none

module rhbs_bar_div #(
  parameter int COUNT_WIDTH = 32,
  parameter int BAR_TOP     = 511
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        start_i,
  input  wire logic [COUNT_WIDTH+$clog2(BAR_TOP+1)-1:0]    dividend_i,
  input  wire logic [COUNT_WIDTH-1:0]                      divisor_i,
  output logic                                             done_o,
  output logic      [$clog2(BAR_TOP+1)-1:0]                bar_o
);

  localparam int BAR_W  = $clog2(BAR_TOP + 1);
  localparam int PROD_W = COUNT_WIDTH + BAR_W;
  localparam int CNT_W  = $clog2(BAR_W + 1);
  localparam logic [BAR_W-1:0] BAR_MAX = BAR_W'(BAR_TOP);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] dvs_q, dvs_d;
  logic [BAR_W-1:0]   low_q, low_d;
  logic [BAR_W-1:0]   quo_q, quo_d;
  logic               over_q, over_d;

  logic [COUNT_WIDTH:0] trial;
  logic [COUNT_WIDTH:0] diff;
  logic                 ge;

  assign trial = {rem_q, low_q[BAR_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    low_d  = low_q;
    quo_d  = quo_q;
    over_d = over_q;
    if (start_i) begin
      // high part >= divisor means the quotient cannot fit: clamp later
      rem_d  = dividend_i[PROD_W-1:BAR_W];
      low_d  = dividend_i[BAR_W-1:0];
      over_d = (dividend_i[PROD_W-1:BAR_W] >= divisor_i);
      dvs_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = CNT_W'(BAR_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      low_d = low_q << 1;
      quo_d = (quo_q << 1) | BAR_W'(ge);
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    over_q <= over_d;
  end

  assign done_o = done_q;
  assign bar_o  = (over_q || (quo_q > BAR_MAX)) ? BAR_MAX : quo_q;

endmodule

`default_nettype wire

// File: rtl/rgb_histogram_bar_scaler_top.sv
// RGB histogram bar scaler, top level.
// Depends on rhbs_pkg, rhbs_ram and rhbs_bar_div.
//
// Usage:
//  - Input stream (s_axis_*): one word per pixel or query. tuser selects the
//    command: accumulate adds the pixel's red, green and blue values to their
//    bins; query reads one bin of each channel and returns a result word.
//  - Output stream (m_axis_*): one word per query, none per accumulate.
//    Each result holds the raw counts, the bars floor(count*BAR_TOP/peak)
//    clamped to BAR_TOP, the longest bar and the running peak (at least 1).
//  - Throughput: one word at a time. An accumulate does a bin read, then the
//    increment and write-back into the three bin RAMs. A query does a bin
//    read, BAR_W steps of the bit-serial bar divider plus its load and finish
//    steps, and the output load that raises m_axis_tvalid.
//  - Reset: the bin RAMs are swept to zero, one entry per cycle, with
//    s_axis_tready low; the peak restarts at one.
//  - Stall: the result register holds while m_axis_tready is low; accumulate
//    words are still taken, and a later query waits only for its own load.
`default_nettype none

module rgb_histogram_bar_scaler_top
  import rhbs_pkg::*;
#(
  parameter int NUM_BINS    = NUM_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int BAR_TOP     = BAR_TOP_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // red, green, blue, bin_index (8 bits each, lowest first)
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // queried_bin, red_count, green_count, blue_count, red_bar, green_bar,
  // blue_bar, longest_bar, peak_count; zero padded to whole bytes
  output logic [((PIX_W + 4*COUNT_WIDTH + 4*$clog2(BAR_TOP+1) + 7) / 8) * 8 - 1:0]
                                     m_axis_tdata
);

  localparam int IDX_W  = $clog2(NUM_BINS);
  localparam int BAR_W  = $clog2(BAR_TOP + 1);
  localparam int CMP_W  = ((IDX_W > PIX_W) ? IDX_W : PIX_W) + 1;
  localparam int PROD_W = COUNT_WIDTH + BAR_W;
  localparam int OUT_W  = PIX_W + 4 * COUNT_WIDTH + 4 * BAR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // FSM codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC   = 3'd2;
  localparam logic [2:0] ST_QRD   = 3'd3;
  localparam logic [2:0] ST_QDIV  = 3'd4;
  localparam logic [2:0] ST_QOUT  = 3'd5;

  function automatic logic in_range(logic [PIX_W-1:0] v);
    return CMP_W'(v) < CMP_W'(NUM_BINS);
  endfunction

  function automatic logic [IDX_W-1:0] to_addr(logic [PIX_W-1:0] v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    return ext[IDX_W-1:0];
  endfunction

  logic [2:0] state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [COUNT_WIDTH-1:0] peak_q, peak_d;

  // captured word
  logic [IDX_W-1:0] addr_r_q, addr_g_q, addr_b_q;
  logic             ok_r_q, ok_g_q, ok_b_q;
  logic [PIX_W-1:0] bin_q;
  logic             bin_ok_q;
  logic [COUNT_WIDTH-1:0] cnt_r_q, cnt_g_q, cnt_b_q;

  logic             out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [PIX_W-1:0] in_red, in_green, in_blue, in_bin;
  logic             accept;
  logic             is_query;
  logic             out_load;

  // RAM ports
  logic             we_r, we_g, we_b;
  logic [IDX_W-1:0] waddr_r, waddr_g, waddr_b;
  logic [IDX_W-1:0] raddr_r, raddr_g, raddr_b;
  logic [COUNT_WIDTH-1:0] wdata_r, wdata_g, wdata_b;
  logic [COUNT_WIDTH-1:0] rdata_r, rdata_g, rdata_b;

  // increment path
  logic [COUNT_WIDTH-1:0] inc_r, inc_g, inc_b;
  logic [COUNT_WIDTH-1:0] pk1, pk2, pk3;

  // query path
  logic [COUNT_WIDTH-1:0] qc_r, qc_g, qc_b;
  logic                   div_start;
  logic                   done_r, done_g, done_b;
  logic [BAR_W-1:0]       bar_r, bar_g, bar_b, bar_long;

  assign in_red   = s_axis_tdata[PIX_W-1:0];
  assign in_green = s_axis_tdata[2*PIX_W-1:PIX_W];
  assign in_blue  = s_axis_tdata[3*PIX_W-1:2*PIX_W];
  assign in_bin   = s_axis_tdata[4*PIX_W-1:3*PIX_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_query      = (s_axis_tuser == CMD_QUERY);

  // Reads issue in the accept cycle; data is back in ST_ACC / ST_QRD.
  assign raddr_r = is_query ? to_addr(in_bin) : to_addr(in_red);
  assign raddr_g = is_query ? to_addr(in_bin) : to_addr(in_green);
  assign raddr_b = is_query ? to_addr(in_bin) : to_addr(in_blue);

  // Saturating increments
  assign inc_r = (rdata_r == CNT_MAX) ? rdata_r : rdata_r + COUNT_WIDTH'(1);
  assign inc_g = (rdata_g == CNT_MAX) ? rdata_g : rdata_g + COUNT_WIDTH'(1);
  assign inc_b = (rdata_b == CNT_MAX) ? rdata_b : rdata_b + COUNT_WIDTH'(1);

  // Peak update over the channels actually counted
  assign pk1 = (ok_r_q && (inc_r > peak_q)) ? inc_r : peak_q;
  assign pk2 = (ok_g_q && (inc_g > pk1))    ? inc_g : pk1;
  assign pk3 = (ok_b_q && (inc_b > pk2))    ? inc_b : pk2;

  // Write port: clearing sweep after reset, else write-back of the increment
  always_comb begin
    if (state_q == ST_CLEAR) begin
      we_r = 1'b1;
      we_g = 1'b1;
      we_b = 1'b1;
      waddr_r = clr_q;
      waddr_g = clr_q;
      waddr_b = clr_q;
      wdata_r = '0;
      wdata_g = '0;
      wdata_b = '0;
    end else begin
      we_r = (state_q == ST_ACC) && ok_r_q;
      we_g = (state_q == ST_ACC) && ok_g_q;
      we_b = (state_q == ST_ACC) && ok_b_q;
      waddr_r = addr_r_q;
      waddr_g = addr_g_q;
      waddr_b = addr_b_q;
      wdata_r = inc_r;
      wdata_g = inc_g;
      wdata_b = inc_b;
    end
  end

  // Out-of-range query reads as zero counts, hence zero bars
  assign qc_r = bin_ok_q ? rdata_r : '0;
  assign qc_g = bin_ok_q ? rdata_g : '0;
  assign qc_b = bin_ok_q ? rdata_b : '0;
  assign div_start = (state_q == ST_QRD);

  always_comb begin
    bar_long = bar_r;
    if (bar_g > bar_long) begin
      bar_long = bar_g;
    end
    if (bar_b > bar_long) begin
      bar_long = bar_b;
    end
  end

  assign out_load = (state_q == ST_QOUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    peak_d  = peak_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = is_query ? ST_QRD : ST_ACC;
        end
      end
      ST_ACC: begin
        peak_d  = pk3;
        state_d = ST_IDLE;
      end
      ST_QRD: begin
        state_d = ST_QDIV;
      end
      ST_QDIV: begin
        // the three dividers run in lock step
        if (done_r && done_g && done_b) begin
          state_d = ST_QOUT;
        end
      end
      ST_QOUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      peak_q      <= COUNT_WIDTH'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      peak_q      <= peak_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_r_q <= to_addr(in_red);
      addr_g_q <= to_addr(in_green);
      addr_b_q <= to_addr(in_blue);
      ok_r_q   <= in_range(in_red);
      ok_g_q   <= in_range(in_green);
      ok_b_q   <= in_range(in_blue);
      bin_q    <= in_bin;
      bin_ok_q <= in_range(in_bin);
    end
    if (div_start) begin
      cnt_r_q <= qc_r;
      cnt_g_q <= qc_g;
      cnt_b_q <= qc_b;
    end
    if (out_load) begin
      out_data_q <= OUT_TDATA_W'({peak_q, bar_long, bar_b, bar_g, bar_r,
                                  cnt_b_q, cnt_g_q, cnt_r_q, bin_q});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  rhbs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram_red (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr_r),
    .wdata_i (wdata_r),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  rhbs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram_green (
    .clk_i   (clk_i),
    .we_i    (we_g),
    .waddr_i (waddr_g),
    .wdata_i (wdata_g),
    .raddr_i (raddr_g),
    .rdata_o (rdata_g)
  );

  rhbs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram_blue (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr_b),
    .wdata_i (wdata_b),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // count * BAR_TOP goes straight into the divider's load registers
  rhbs_bar_div #(.COUNT_WIDTH(COUNT_WIDTH), .BAR_TOP(BAR_TOP)) u_div_red (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(qc_r) * PROD_W'(BAR_TOP)),
    .divisor_i  (peak_q),
    .done_o     (done_r),
    .bar_o      (bar_r)
  );

  rhbs_bar_div #(.COUNT_WIDTH(COUNT_WIDTH), .BAR_TOP(BAR_TOP)) u_div_green (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(qc_g) * PROD_W'(BAR_TOP)),
    .divisor_i  (peak_q),
    .done_o     (done_g),
    .bar_o      (bar_g)
  );

  rhbs_bar_div #(.COUNT_WIDTH(COUNT_WIDTH), .BAR_TOP(BAR_TOP)) u_div_blue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(qc_b) * PROD_W'(BAR_TOP)),
    .divisor_i  (peak_q),
    .done_o     (done_b),
    .bar_o      (bar_b)
  );

endmodule

`default_nettype wire

// File: rtl/rhbs_checker.sv
// Port-level checks for the histogram block, bound to the top level.
// Depends on rhbs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhbs_checker
  import rhbs_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int BAR_TOP     = BAR_TOP_DEF
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [((PIX_W + 4*COUNT_WIDTH + 4*$clog2(BAR_TOP+1) + 7) / 8) * 8 - 1:0]
                                    m_axis_tdata
);

  localparam int OUT_W = PIX_W + 4 * COUNT_WIDTH + 4 * $clog2(BAR_TOP + 1);

  logic in_acc;
  logic acc_word;
  logic qry_word;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign acc_word = in_acc && (s_axis_tuser == CMD_ACCUM);
  assign qry_word = in_acc && (s_axis_tuser == CMD_QUERY);

  // Bin clearing sweep keeps the input closed straight after reset
  `RHBS_ASSERT(a_clear_after_reset, clk_i, rst_ni,
               $rose(rst_ni) |-> !s_axis_tready, "input open during clear")

  // An accumulate word never produces a result word
  `RHBS_ASSERT(a_acc_silent, clk_i, rst_ni,
               (acc_word && !m_axis_tvalid) |=> !m_axis_tvalid, "result from accumulate")

  // A query occupies the block: no word taken in the next cycle
  `RHBS_ASSERT(a_query_busy, clk_i, rst_ni,
               qry_word |=> !s_axis_tready, "input open during query")

  // Peak field is never zero
  `RHBS_NEVER(a_peak_nonzero, clk_i, rst_ni,
              m_axis_tvalid && (m_axis_tdata[OUT_W-1 -: COUNT_WIDTH] == '0), "zero peak")

  // Stalled result holds
  `RHBS_ASSERT(a_out_hold, clk_i, rst_ni,
               (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
               "stalled result changed")

endmodule

bind rgb_histogram_bar_scaler_top rhbs_checker #(
  .COUNT_WIDTH (COUNT_WIDTH),
  .BAR_TOP     (BAR_TOP)
) u_rhbs_checker (.*);

`default_nettype wire
